FILE: rtl/core/mrfe_pkg.sv
// Shared types and codes for the MIPS relocation fixup engine.
// Used by every module under rtl/core; depends on nothing.
package mrfe_pkg;

    localparam int ADDR_W  = 32;
    localparam int WORD_W  = 32;
    localparam int SIZE_W  = 24;
    localparam int TYPE_W  = 6;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALLOC_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_SIZE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_SIZE  = 2'd3;

    // Section selector codes
    localparam logic [1:0] SEC_NONE  = 2'd0;
    localparam logic [1:0] SEC_ALLOC = 2'd1;
    localparam logic [1:0] SEC_DATA  = 2'd2;
    localparam logic [1:0] SEC_BSS   = 2'd3;

    // Relocation type codes
    localparam logic [TYPE_W-1:0] RTYPE_WORD32 = 6'd2;
    localparam logic [TYPE_W-1:0] RTYPE_JUMP26 = 6'd4;
    localparam logic [TYPE_W-1:0] RTYPE_HI16   = 6'd5;
    localparam logic [TYPE_W-1:0] RTYPE_LO16   = 6'd6;

    typedef struct packed {
        logic [ADDR_W-1:0] alloc_base;
        logic [ADDR_W-1:0] sec2_base;
        logic [ADDR_W-1:0] sec3_base;
        logic [ADDR_W-1:0] delta;      // alloc_base - link_base
    } mrfe_cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] write_address;
        logic [WORD_W-1:0] write_data;
        logic              run_end;
    } mrfe_result_t;

    // count 2: hi write then main write; count 1: main write only
    typedef struct packed {
        logic [1:0]   count;
        mrfe_result_t hi;
        mrfe_result_t main;
    } mrfe_pair_t;

endpackage

FILE: rtl/core/mrfe_cfg.sv
// Configuration registers with precomputed section bases and rebase delta.
// Depends on mrfe_pkg.
module mrfe_cfg
    import mrfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    output mrfe_cfg_t            cfg
);

    logic [ADDR_W-1:0] alloc_reg, alloc_next;
    logic [ADDR_W-1:0] link_reg, link_next;
    logic [SIZE_W-1:0] text_reg, text_next;
    logic [SIZE_W-1:0] data_reg, data_next;
    logic [ADDR_W-1:0] sec2_reg, sec2_next;
    logic [ADDR_W-1:0] sec3_reg, sec3_next;
    logic [ADDR_W-1:0] delta_reg, delta_next;

    always_comb
    begin
        alloc_next = alloc_reg;
        link_next  = link_reg;
        text_next  = text_reg;
        data_next  = data_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ALLOC_BASE: alloc_next = cfg_wdata;
                REG_LINK_BASE:  link_next  = cfg_wdata;
                REG_TEXT_SIZE:  text_next  = cfg_wdata[SIZE_W-1:0];
                REG_DATA_SIZE:  data_next  = cfg_wdata[SIZE_W-1:0];
            endcase
        end
        sec2_next  = alloc_next + {{(ADDR_W-SIZE_W){1'b0}}, text_next};
        sec3_next  = sec2_next + {{(ADDR_W-SIZE_W){1'b0}}, data_next};
        delta_next = alloc_next - link_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg <= '0;
            link_reg  <= '0;
            text_reg  <= '0;
            data_reg  <= '0;
            sec2_reg  <= '0;
            sec3_reg  <= '0;
            delta_reg <= '0;
        end
        else
        begin
            alloc_reg <= alloc_next;
            link_reg  <= link_next;
            text_reg  <= text_next;
            data_reg  <= data_next;
            sec2_reg  <= sec2_next;
            sec3_reg  <= sec3_next;
            delta_reg <= delta_next;
        end
    end

    assign cfg.alloc_base = alloc_reg;
    assign cfg.sec2_base  = sec2_reg;
    assign cfg.sec3_base  = sec3_reg;
    assign cfg.delta      = delta_reg;

endmodule

FILE: rtl/core/mrfe_calc.sv
// Input register, pending hi16 state and the fixup logic for one entry.
// Depends on mrfe_pkg; feeds a result pair to mrfe_outbuf.
module mrfe_calc
    import mrfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mrfe_cfg_t         cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ADDR_W-1:0] reloc_entry,
    input  logic [WORD_W-1:0] target_word,
    input  logic              last_entry,
    input  logic              free,
    output logic              load,
    output mrfe_pair_t        pair
);

    logic              in_valid_reg, in_valid_next;
    logic [ADDR_W-1:0] entry_reg;
    logic [WORD_W-1:0] word_reg;
    logic              last_reg;

    logic [ADDR_W-1:0] phi_addr_reg, phi_addr_next;
    logic [WORD_W-1:0] phi_word_reg, phi_word_next;
    logic              phi_valid_reg, phi_valid_next;

    logic [1:0]        sec;
    logic [TYPE_W-1:0] rtype;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] lo_sum;
    logic [15:0]       hi_half;
    logic [ADDR_W-1:0] jump_rb;
    logic              take;

    assign s_tready = !in_valid_reg || free;
    assign take     = s_tvalid && s_tready;
    assign load     = in_valid_reg && free;

    assign sec   = entry_reg[31:30];
    assign rtype = entry_reg[29:24];

    always_comb
    begin
        unique case (sec)
            SEC_NONE:  base = '0;
            SEC_ALLOC: base = cfg.alloc_base;
            SEC_DATA:  base = cfg.sec2_base;
            SEC_BSS:   base = cfg.sec3_base;
        endcase
    end

    assign addr    = base + {8'b0, entry_reg[23:0]};
    assign lo_sum  = {phi_word_reg[15:0], 16'b0} + {{16{word_reg[15]}}, word_reg[15:0]}
                     + cfg.delta;
    assign hi_half = lo_sum[31:16] + {15'b0, lo_sum[15]};
    assign jump_rb = {1'b1, 3'b0, word_reg[25:0], 2'b00} + cfg.delta;

    // result pair and pending state update
    always_comb
    begin
        pair                    = '0;
        pair.main.write_address = addr;
        pair.main.run_end       = 1'b1;
        pair.hi.write_address   = phi_addr_reg;
        pair.hi.write_data      = {phi_word_reg[31:16], hi_half};
        pair.hi.run_end         = 1'b0;
        phi_addr_next           = phi_addr_reg;
        phi_word_next           = phi_word_reg;
        phi_valid_next          = phi_valid_reg;
        unique case (rtype)
            RTYPE_WORD32:
            begin
                pair.main.write_data = word_reg + cfg.delta;
                pair.count = (word_reg[27:24] == 4'd0) ? 2'd1 : 2'd0;
            end
            RTYPE_JUMP26:
            begin
                pair.main.write_data = {word_reg[31:26], jump_rb[27:2]};
                pair.count = 2'd1;
            end
            RTYPE_HI16:
            begin
                phi_addr_next  = addr;
                phi_word_next  = word_reg;
                phi_valid_next = 1'b1;
            end
            RTYPE_LO16:
            begin
                pair.main.write_data = {word_reg[31:16], lo_sum[15:0]};
                pair.count = phi_valid_reg ? 2'd2 : 2'd1;
                phi_valid_next = 1'b0;
            end
            default:
            begin
                pair.count = 2'd0;
            end
        endcase
        // drop pending hi at the end of a table
        if (last_reg)
        begin
            phi_addr_next  = '0;
            phi_word_next  = '0;
            phi_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        if (take)
            in_valid_next = 1'b1;
        else if (load)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            phi_addr_reg  <= '0;
            phi_word_reg  <= '0;
            phi_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (load)
            begin
                phi_addr_reg  <= phi_addr_next;
                phi_word_reg  <= phi_word_next;
                phi_valid_reg <= phi_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg <= reloc_entry;
            word_reg  <= target_word;
            last_reg  <= last_entry;
        end
    end

endmodule

FILE: rtl/core/mrfe_outbuf.sv
// Result register holding up to two writes, drained one item per cycle while m_tready is high.
// Depends on mrfe_pkg.
module mrfe_outbuf
    import mrfe_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  mrfe_pair_t                 pair,
    output logic                       free,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ADDR_W+WORD_W-1:0]   m_tdata,
    output logic                       m_tlast
);

    logic [1:0]   cnt_reg, cnt_next;
    mrfe_result_t hi_reg;
    mrfe_result_t main_reg;
    mrfe_result_t cur;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign free     = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign cur      = (cnt_reg == 2'd2) ? hi_reg : main_reg;
    assign m_tdata  = {cur.write_data, cur.write_address};
    assign m_tlast  = cur.run_end;

    always_comb
    begin
        if (load)
            cnt_next = pair.count;
        else if (m_tvalid && m_tready)
            cnt_next = cnt_reg - 2'd1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hi_reg   <= pair.hi;
            main_reg <= pair.main;
        end
    end

endmodule

FILE: rtl/core/mips_reloc_fixup_engine_core.sv
// MIPS relocation fixup engine, top level. Uses mrfe_pkg, mrfe_cfg, mrfe_calc, mrfe_outbuf.
// Path: an accepted entry is held in the input register of mrfe_calc, then moved into the
// result register of mrfe_outbuf, from which its writes are presented on the m side.
// Throughput: one entry per cycle while m_tready is high; a lo16 with a pending hi16
// puts two writes in the result register, holding the input register until the hi16 is out.
// Reset (rst_n, async, active low) clears config, pending hi16 state and valids, not data.
module mips_reloc_fixup_engine_core
    import mrfe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [ADDR_W-1:0]        cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [ADDR_W+WORD_W-1:0] s_tdata,   // reloc_entry[31:0], target_word[63:32]
    input  logic                     s_tlast,   // last_entry
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [ADDR_W+WORD_W-1:0] m_tdata,   // write_address[31:0], write_data[63:32]
    output logic                     m_tlast    // run_end
);

    mrfe_cfg_t  cfg;
    mrfe_pair_t pair;
    logic       free;
    logic       load;

    mrfe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mrfe_calc u_calc (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .reloc_entry (s_tdata[ADDR_W-1:0]),
        .target_word (s_tdata[ADDR_W+WORD_W-1:ADDR_W]),
        .last_entry  (s_tlast),
        .free        (free),
        .load        (load),
        .pair        (pair)
    );

    mrfe_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .pair     (pair),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for mips_reloc_fixup_engine_core: directed table, then random phases.
// Patches are predicted in-line from the relocation rules and compared as they leave the m side.
// Depends on mrfe_pkg and the RTL under rtl/core.
module tb_top;
    import mrfe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STUCK_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [31:0]  entry;
        logic [31:0]  word;
        logic         last;
        int           n_typed;    // -1: use the predictor
        mrfe_result_t p0;
        mrfe_result_t p1;
    } dir_row_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_ALLOC_BASE;
    logic [ADDR_W-1:0]        cfg_wdata = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [ADDR_W+WORD_W-1:0] s_tdata = '0;
    logic                     s_tlast = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [ADDR_W+WORD_W-1:0] m_tdata;
    logic                     m_tlast;

    // configuration as the block holds it
    logic [31:0] cur_alloc = '0;
    logic [31:0] cur_link  = '0;
    logic [31:0] cur_text  = '0;
    logic [31:0] cur_data  = '0;

    // held lui of the last hi16
    logic [31:0] lui_addr = '0;
    logic [31:0] lui_word = '0;
    logic        lui_pending = 1'b0;

    mrfe_result_t patch_q[$];
    mrfe_result_t want;
    dir_row_t     dir_rows[$];

    int err_cnt = 0;
    int stuck_cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    mips_reloc_fixup_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic mrfe_result_t mk_patch(input logic [31:0] addr, input logic [31:0] data,
                                              input logic run_end);
        mrfe_result_t p;
        p.write_address = addr;
        p.write_data    = data;
        p.run_end       = run_end;
        return p;
    endfunction

    // Apply one relocation entry to the held state; return the patches it makes.
    function automatic int predict_patches(input logic [31:0] entry, input logic [31:0] word,
                                           input logic last, output mrfe_result_t p0,
                                           output mrfe_result_t p1);
        logic [31:0]  base;
        logic [31:0]  addr;
        logic [31:0]  tgt;
        logic [31:0]  moved;
        logic [31:0]  slo;
        logic [15:0]  hi_half;
        mrfe_result_t lo_patch;
        int           n;
        n  = 0;
        p0 = '0;
        p1 = '0;
        case (entry[31:30])
            SEC_NONE:  base = '0;
            SEC_ALLOC: base = cur_alloc;
            SEC_DATA:  base = cur_alloc + cur_text;
            default:   base = cur_alloc + cur_text + cur_data;
        endcase
        addr = base + {8'h00, entry[23:0]};
        case (entry[29:24])
            RTYPE_WORD32:
            begin
                if (word[27:24] == 4'h0)
                begin
                    p0 = mk_patch(addr, word - cur_link + cur_alloc, 1'b1);
                    n  = 1;
                end
            end
            RTYPE_JUMP26:
            begin
                tgt   = {4'b1000, word[25:0], 2'b00};
                moved = tgt - cur_link + cur_alloc;
                p0    = mk_patch(addr, {word[31:26], moved[27:2]}, 1'b1);
                n     = 1;
            end
            RTYPE_HI16:
            begin
                lui_addr    = addr;
                lui_word    = word;
                lui_pending = 1'b1;
            end
            RTYPE_LO16:
            begin
                slo = {{16{word[15]}}, word[15:0]};
                moved = {lui_word[15:0], 16'h0000} + slo - cur_link + cur_alloc;
                if (lui_pending)
                begin
                    // carry from the low half goes into the lui immediate
                    hi_half = moved[31:16] + {15'h0000, moved[15]};
                    p0 = mk_patch(lui_addr, {lui_word[31:16], hi_half}, 1'b0);
                    n  = 1;
                    lui_pending = 1'b0;
                end
                lo_patch = mk_patch(addr, {word[31:16], moved[15:0]}, 1'b1);
                if (n == 0)
                    p0 = lo_patch;
                else
                    p1 = lo_patch;
                n++;
            end
            default: ;
        endcase
        if (last)
        begin
            lui_addr    = '0;
            lui_word    = '0;
            lui_pending = 1'b0;
        end
        return n;
    endfunction

    function automatic void add_row(input logic [31:0] entry, input logic [31:0] word,
                                    input logic last, input int n_typed,
                                    input mrfe_result_t p0, input mrfe_result_t p1);
        dir_row_t r;
        r.entry   = entry;
        r.word    = word;
        r.last    = last;
        r.n_typed = n_typed;
        r.p0      = p0;
        r.p1      = p1;
        dir_rows.push_back(r);
    endfunction

    // Offer one item, wait for it to be taken, then record what it should produce.
    task automatic offer_entry(input logic [31:0] entry, input logic [31:0] word,
                               input logic last, input int n_typed,
                               input mrfe_result_t t0, input mrfe_result_t t1);
        mrfe_result_t p0;
        mrfe_result_t p1;
        int           n;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {word, entry};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n = predict_patches(entry, word, last, p0, p1);
        if (n_typed >= 0)
        begin
            n  = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            patch_q.push_back(p0);
        if (n > 1)
            patch_q.push_back(p1);
    endtask

    task automatic offer_checked(input logic [31:0] entry, input logic [31:0] word,
                                 input logic last);
        offer_entry(entry, word, last, -1, '0, '0);
    endtask

    // Drop valid and wait until every patch has come out and the pipe is quiet.
    task automatic drain_patches();
        s_tvalid <= 1'b0;
        while (patch_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed tables: hi16/lo16 pairs, word32 and jump26, plus some noise.
    task automatic random_entries(input int count);
        int          sent;
        int          k;
        int          nlo;
        int          j;
        logic [31:0] r1;
        logic [31:0] r2;
        logic [31:0] w;
        logic        lst;
        sent = 0;
        while (sent < count)
        begin
            k   = $urandom_range(99);
            r1  = $urandom();
            w   = $urandom();
            lst = ($urandom_range(99) < 4);
            if (k < 18)
            begin
                if ($urandom_range(3) != 0)
                    w[27:24] = 4'h0;
                offer_checked({r1[31:30], RTYPE_WORD32, r1[23:0]}, w, lst);
                sent++;
            end
            else if (k < 34)
            begin
                offer_checked({r1[31:30], RTYPE_JUMP26, r1[23:0]}, w, lst);
                sent++;
            end
            else if (k < 74)
            begin
                offer_checked({r1[31:30], RTYPE_HI16, r1[23:0]}, w, 1'b0);
                nlo = ($urandom_range(3) == 0) ? 2 : 1;
                for (j = 0; j < nlo; j++)
                begin
                    r2 = $urandom();
                    offer_checked({r2[31:30], RTYPE_LO16, r2[23:0]}, $urandom(), lst);
                end
                sent += 1 + nlo;
            end
            else if (k < 82)
            begin
                offer_checked({r1[31:30], RTYPE_LO16, r1[23:0]}, w, lst);
                sent++;
            end
            else if (k < 88)
            begin
                offer_checked({r1[31:30], RTYPE_HI16, r1[23:0]}, w, lst);
                sent++;
            end
            else
            begin
                offer_checked(r1, w, lst);
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] alloc, input logic [31:0] link,
                             input logic [23:0] text, input logic [23:0] data,
                             input int idle, input int stall, input int count,
                             input logic hold);
        drain_patches();
        cfg_we    <= 1'b1;
        cfg_index <= REG_ALLOC_BASE;
        cfg_wdata <= alloc;
        @(posedge clk);
        cfg_index <= REG_LINK_BASE;
        cfg_wdata <= link;
        @(posedge clk);
        cfg_index <= REG_TEXT_SIZE;
        cfg_wdata <= {8'h00, text};
        @(posedge clk);
        cfg_index <= REG_DATA_SIZE;
        cfg_wdata <= {8'h00, data};
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_alloc = alloc;
        cur_link  = link;
        cur_text  = {8'h00, text};
        cur_data  = {8'h00, data};
        idle_pct  = idle;
        stall_pct = stall;
        if (hold)
            hold_asked++;
        random_entries(count);
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (patch_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected patch: addr %h data %h run_end %b",
                             $time, m_tdata[31:0], m_tdata[63:32], m_tlast);
                end
                else
                begin
                    want = patch_q.pop_front();
                    if (m_tdata[31:0] !== want.write_address)
                    begin
                        err_cnt++;
                        $display("%0t: write_address expected %h got %h",
                                 $time, want.write_address, m_tdata[31:0]);
                    end
                    if (m_tdata[63:32] !== want.write_data)
                    begin
                        err_cnt++;
                        $display("%0t: write_data expected %h got %h",
                                 $time, want.write_data, m_tdata[63:32]);
                    end
                    if (m_tlast !== want.run_end)
                    begin
                        err_cnt++;
                        $display("%0t: run_end expected %b got %b",
                                 $time, want.run_end, m_tlast);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] same_base;
        // reset configuration is all zero, so these patches can be read off directly
        add_row(32'h0200_0000, 32'h0000_0000, 1'b0, 1, mk_patch(32'h0, 32'h0, 1'b1), '0);
        add_row(32'hC2FF_FFFF, 32'hF0FF_FFFF, 1'b0, 1,
                mk_patch(32'h00FF_FFFF, 32'hF0FF_FFFF, 1'b1), '0);
        add_row(32'h4200_0010, 32'h0F00_0000, 1'b0, 0, '0, '0);
        add_row(32'h8400_0004, 32'hFFFF_FFFF, 1'b0, 1,
                mk_patch(32'h4, 32'hFFFF_FFFF, 1'b1), '0);
        add_row(32'h0400_0000, 32'h0000_0000, 1'b0, 1, mk_patch(32'h0, 32'h0, 1'b1), '0);
        // lo16 with nothing held after reset
        add_row(32'h0600_0008, 32'h1234_8000, 1'b0, 1,
                mk_patch(32'h8, 32'h1234_8000, 1'b1), '0);
        // hi16/lo16 pair with carry into the lui
        add_row(32'h4500_0100, 32'h3C01_FFFF, 1'b0, 0, '0, '0);
        add_row(32'h4600_0104, 32'h2421_8000, 1'b0, 2,
                mk_patch(32'h100, 32'h3C01_FFFF, 1'b0), mk_patch(32'h104, 32'h2421_8000, 1'b1));
        // types that produce nothing
        add_row(32'hFF00_0000, 32'hFFFF_FFFF, 1'b0, 0, '0, '0);
        add_row(32'h0000_0000, 32'h0000_0000, 1'b0, 0, '0, '0);
        add_row(32'h0100_0000, 32'h1234_5678, 1'b0, 0, '0, '0);
        add_row(32'h0300_0000, 32'h1234_5678, 1'b0, 0, '0, '0);
        add_row(32'h8700_0000, 32'h1234_5678, 1'b0, 0, '0, '0);
        add_row(32'h2200_0000, 32'h0000_0000, 1'b0, 0, '0, '0);
        // hi16 on the last entry is dropped
        add_row(32'h0500_0200, 32'h3C02_0001, 1'b1, 0, '0, '0);
        add_row(32'h0600_0204, 32'h2442_0010, 1'b0, 1,
                mk_patch(32'h204, 32'h2442_0010, 1'b1), '0);
        // newer hi16 replaces older, second lo16 reuses the held word
        add_row(32'h4500_0300, 32'h3C03_1234, 1'b0, -1, '0, '0);
        add_row(32'h8500_0400, 32'h3C04_8000, 1'b0, -1, '0, '0);
        add_row(32'h4600_0404, 32'h2484_7FFF, 1'b0, -1, '0, '0);
        add_row(32'h4600_0408, 32'h8C85_FFFF, 1'b0, -1, '0, '0);
        add_row(32'hC500_0500, 32'h3C05_0000, 1'b0, -1, '0, '0);
        add_row(32'h0600_0504, 32'h24A5_0001, 1'b1, -1, '0, '0);
        add_row(32'h0600_0508, 32'h0000_0000, 1'b0, 1, mk_patch(32'h508, 32'h0, 1'b1), '0);
        // last entry on a word32 clears a held hi16
        add_row(32'h0500_0600, 32'hFFFF_FFFF, 1'b0, -1, '0, '0);
        add_row(32'h0200_0604, 32'h0000_0000, 1'b1, 1, mk_patch(32'h604, 32'h0, 1'b1), '0);
        add_row(32'h0600_0608, 32'hFFFF_FFFF, 1'b0, 1,
                mk_patch(32'h608, 32'hFFFF_FFFF, 1'b1), '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer_entry(dir_rows[i].entry, dir_rows[i].word, dir_rows[i].last,
                        dir_rows[i].n_typed, dir_rows[i].p0, dir_rows[i].p1);

        run_phase(32'h0, 32'h0, 24'h0, 24'h0, 0, 0, 260, 1'b0);
        run_phase($urandom(), $urandom(), 24'($urandom()), 24'($urandom()), 47, 0, 265, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 0, 47, 265, 1'b0);
        run_phase($urandom(), $urandom(), 24'($urandom()), 24'($urandom()), 13, 13, 265, 1'b0);
        same_base = $urandom();
        // receiver holds off while the sender keeps offering
        run_phase(same_base, same_base, 24'($urandom()), 24'($urandom()), 0, 0, 265, 1'b1);
        run_phase($urandom(), $urandom(), 24'hFF_FFFF, 24'h0, 47, 47, 265, 1'b0);

        drain_patches();
        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/mrfe_pkg.sv
rtl/core/mrfe_cfg.sv
rtl/core/mrfe_calc.sv
rtl/core/mrfe_outbuf.sv
rtl/core/mips_reloc_fixup_engine_core.sv
verif/tb_top.sv
